// ----- hdl/dhkt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhkt_pkg
// Shared widths, codes and item types of the double-hashing key table.
// ----------------------------------------------------------------------------
package dhkt_pkg;

    localparam int KEY_W            = 31;
    localparam int SIZE_W           = 9;
    localparam int SLOT_W           = 8;
    localparam int PAY_OUT_W        = 32;
    localparam int STATUS_W         = 3;
    localparam int SIZE_MIN         = 3;
    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_PAYLOAD_BITS = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET     = 9'd256;
    localparam logic [0:0]        CFG_TABLE_SIZE = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef struct packed {
        action_t                action;
        logic [KEY_W-1:0]       key;
        logic [PAY_OUT_W-1:0]   payload;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        logic [PAY_OUT_W-1:0]   found_payload;
    } out_item_t;

    // memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/double_hash_key_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted item is divided bit-serially in S_HASH, then probed in
// S_PROBE with P probes (1 to the working size), then loaded out in S_OUT.
// Flow: one item at a time; s_ready rises with m_valid, and a result still
// waiting for m_ready holds the next.
// Reset: a clearing pass writes every slot empty with s_ready low; table_size
// resets to 256.
// ----------------------------------------------------------------------------
// double_hash_key_table
// Open-addressing key table with double hashing, insert and lookup items,
// APB-style configuration of the working table size.
// ----------------------------------------------------------------------------
module double_hash_key_table
    import dhkt_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
)(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int WORD_W    = 1 + KEY_W + PAYLOAD_BITS;
    localparam int PAY_EXT_W = (PAYLOAD_BITS > PAY_OUT_W) ? PAYLOAD_BITS : PAY_OUT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic [SIZE_W-1:0]       size_cfg_reg;
    logic [SIZE_W-1:0]       size_reg;
    action_t                 action_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [SIZE_W-1:0]       idx_reg;
    logic [SIZE_W-1:0]       step_reg;
    logic [SIZE_W-1:0]       issue_cnt_reg;
    logic [SIZE_W-1:0]       rd_idx_reg;
    logic                    rd_pend_reg;
    logic [SIZE_W-1:0]       entry_cnt_reg;
    out_item_t               res_reg;
    out_item_t               m_item_reg;
    logic                    m_valid_reg;

    logic [SIZE_W-1:0]       work_size;
    logic                    in_accept;
    logic                    cfg_write;
    logic                    div_done;
    logic [SIZE_W-1:0]       rem_a;
    logic [SIZE_W-1:0]       rem_b;

    mem_ctrl_t               mem_ctrl;
    logic [AW-1:0]           mem_addr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [WORD_W-1:0]       mem_rdata;

    logic                    rd_used;
    logic [KEY_W-1:0]        rd_key;
    logic [PAY_EXT_W-1:0]    rd_pay_ext;
    logic [PAY_EXT_W-1:0]    in_pay_ext;
    logic                    hit;
    logic                    exhausted;
    logic                    issue;
    logic                    room;
    logic                    do_insert;
    logic [SIZE_W:0]         idx_sum;
    logic [SIZE_W-1:0]       idx_adv;
    out_item_t               probe_res;

    // configuration register
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[CFG_ADDR_W-1:2] == CFG_TABLE_SIZE) ?
                       CFG_DATA_W'(size_cfg_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= SIZE_RESET;
        end else if (cfg_write && (paddr[CFG_ADDR_W-1:2] == CFG_TABLE_SIZE)) begin
            size_cfg_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // clamp the configured size to the usable range
    always_comb begin
        if (size_cfg_reg < SIZE_W'(SIZE_MIN)) begin
            work_size = SIZE_W'(SIZE_MIN);
        end else if (32'(size_cfg_reg) > TABLE_DEPTH) begin
            work_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            work_size = size_cfg_reg;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;
    assign in_pay_ext = PAY_EXT_W'(s_item.payload);

    // first slot and step
    dhkt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_accept),
        .key     (s_item.key),
        .div_a   (work_size),
        .div_b   (work_size - 1'b1),
        .done    (div_done),
        .rem_a   (rem_a),
        .rem_b   (rem_b)
    );

    // slot word fields
    assign rd_used    = mem_rdata[WORD_W-1];
    assign rd_key     = mem_rdata[WORD_W-2 -: KEY_W];
    assign rd_pay_ext = PAY_EXT_W'(mem_rdata[PAYLOAD_BITS-1:0]);

    // probe decision on the word read in the previous cycle
    assign hit       = rd_pend_reg && (!rd_used || (rd_key == key_reg));
    assign exhausted = !rd_pend_reg && (issue_cnt_reg == size_reg);
    assign issue     = (state_reg == S_PROBE) && !hit && (issue_cnt_reg < size_reg);
    assign room      = (({1'b0, entry_cnt_reg} + 1'b1) < {1'b0, size_reg});
    assign do_insert = (state_reg == S_PROBE) && hit && !rd_used &&
                       (action_reg == ACT_INSERT) && room;

    // advance the probe index, wrapping modulo the working size
    always_comb begin
        idx_sum = {1'b0, idx_reg} + {1'b0, step_reg};
        if (idx_sum >= {1'b0, size_reg}) begin
            idx_adv = SIZE_W'(idx_sum - {1'b0, size_reg});
        end else begin
            idx_adv = idx_sum[SIZE_W-1:0];
        end
    end

    // result of a finished probe
    always_comb begin
        probe_res.status        = ST_NOT_FOUND;
        probe_res.slot          = '0;
        probe_res.found_payload = '0;
        if (hit) begin
            if (rd_used) begin
                probe_res.status = (action_reg == ACT_INSERT) ? ST_DUPLICATE : ST_FOUND;
                probe_res.slot          = rd_idx_reg[SLOT_W-1:0];
                probe_res.found_payload = rd_pay_ext[PAY_OUT_W-1:0];
            end else if (action_reg == ACT_INSERT) begin
                if (room) begin
                    probe_res.status = ST_INSERTED;
                    probe_res.slot   = rd_idx_reg[SLOT_W-1:0];
                end else begin
                    probe_res.status = ST_FULL;
                end
            end
        end else if (action_reg == ACT_INSERT) begin
            probe_res.status = ST_FULL;
        end
    end

    // memory port: clearing pass, probe reads, insert write
    always_comb begin
        mem_ctrl.rd_en = 1'b0;
        mem_ctrl.wr_en = 1'b0;
        mem_addr       = AW'(idx_reg);
        mem_wdata      = {1'b1, key_reg, pay_reg};
        if (state_reg == S_CLEAR) begin
            mem_ctrl.wr_en = 1'b1;
            mem_addr       = clr_addr_reg;
            mem_wdata      = '0;
        end else if (do_insert) begin
            mem_ctrl.wr_en = 1'b1;
            mem_addr       = AW'(rd_idx_reg);
        end else if (issue) begin
            mem_ctrl.rd_en = 1'b1;
        end
    end

    dhkt_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WORD_W (WORD_W)
    ) u_mem (
        .aclk  (aclk),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // control sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            entry_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // raise valid when a result is loaded, drop it once taken
            if ((state_reg == S_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(TABLE_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_item.action;
                        key_reg    <= s_item.key;
                        pay_reg    <= in_pay_ext[PAYLOAD_BITS-1:0];
                        size_reg   <= work_size;
                        state_reg  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (div_done) begin
                        idx_reg       <= rem_a;
                        step_reg      <= (rem_b == '0) ? SIZE_W'(1) : rem_b;
                        issue_cnt_reg <= '0;
                        rd_pend_reg   <= 1'b0;
                        state_reg     <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // no read is issued on the last probe, so the pending flag drops
                    rd_pend_reg <= issue;
                    rd_idx_reg  <= idx_reg;
                    if (issue) begin
                        idx_reg       <= idx_adv;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (hit || exhausted) begin
                        res_reg     <= probe_res;
                        state_reg   <= S_OUT;
                        if (do_insert) begin
                            entry_cnt_reg <= entry_cnt_reg + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

// ----- hdl/dhkt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhkt_div
// Bit-serial remainder unit: key mod div_a and key mod div_b, one key bit
// per cycle for both divisors.
// ----------------------------------------------------------------------------
module dhkt_div
    import dhkt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [SIZE_W-1:0] div_a,
    input  wire logic [SIZE_W-1:0] div_b,
    output logic                   done,
    output logic [SIZE_W-1:0]      rem_a,
    output logic [SIZE_W-1:0]      rem_b
);

    localparam int CNT_W = $clog2(KEY_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [KEY_W-1:0]  key_sh_reg;
    logic [SIZE_W-1:0] da_reg;
    logic [SIZE_W-1:0] db_reg;
    logic [SIZE_W-1:0] ra_reg;
    logic [SIZE_W-1:0] rb_reg;

    logic [SIZE_W:0]   ta;
    logic [SIZE_W:0]   tb;
    logic [SIZE_W-1:0] ra_next;
    logic [SIZE_W-1:0] rb_next;

    // shift in the next key bit and subtract where it fits
    always_comb begin
        ta = {ra_reg, key_sh_reg[KEY_W-1]};
        tb = {rb_reg, key_sh_reg[KEY_W-1]};
        if (ta >= {1'b0, da_reg}) begin
            ra_next = SIZE_W'(ta - {1'b0, da_reg});
        end else begin
            ra_next = ta[SIZE_W-1:0];
        end
        if (tb >= {1'b0, db_reg}) begin
            rb_next = SIZE_W'(tb - {1'b0, db_reg});
        end else begin
            rb_next = tb[SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                key_sh_reg <= key;
                da_reg     <= div_a;
                db_reg     <= div_b;
                ra_reg     <= '0;
                rb_reg     <= '0;
            end else if (busy_reg) begin
                ra_reg     <= ra_next;
                rb_reg     <= rb_next;
                key_sh_reg <= {key_sh_reg[KEY_W-2:0], 1'b0};
                cnt_reg    <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(KEY_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign rem_a = ra_reg;
    assign rem_b = rb_reg;

endmodule
`default_nettype wire

// ----- hdl/dhkt_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhkt_mem
// Single-port slot memory, one entry per slot: used flag, key, payload.
// Read data is registered.
// ----------------------------------------------------------------------------
module dhkt_mem
    import dhkt_pkg::*;
#(
    parameter int DEPTH  = DEF_TABLE_DEPTH,
    parameter int WORD_W = 1 + KEY_W + DEF_PAYLOAD_BITS
)(
    input  wire logic                     aclk,
    input  wire mem_ctrl_t                ctrl,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WORD_W-1:0]        wdata,
    output logic [WORD_W-1:0]             rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // write wins; the controller never issues both
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wdata;
        end else if (ctrl.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- bench/double_hash_key_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_key_table_tb
// Self-checking bench for the double-hashing key table. A queue-fed driver
// offers insert and lookup items, a scoreboard model predicts each result at
// input accept, and a monitor compares every result field by field. Phases
// move the table size through clamped, small, mid and full-depth settings,
// filling the table until it reports full and then shrinking it again.
// ----------------------------------------------------------------------------
module double_hash_key_table_tb
    import dhkt_pkg::*;
;

    localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int unsigned HOLD_CYCLES = 1500;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = KEY_W + 4 + TABLE_DEPTH + 16;
    localparam int unsigned NUM_PHASES  = 11;

    localparam logic [CFG_ADDR_W-1:0] ADDR_TABLE_SIZE = CFG_ADDR_W'(CFG_TABLE_SIZE) << 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = CFG_ADDR_W'(CFG_TABLE_SIZE + 1) << 2;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // phase plan: table size written, item count, share of fresh inserts
    int unsigned phase_size  [NUM_PHASES] = '{12, 2, 24, 61, 128, 511, 256, 5, 257, 3, 100};
    int unsigned phase_items [NUM_PHASES] = '{40, 30, 60, 120, 200, 150, 500, 80, 80, 60, 150};
    int unsigned phase_fresh [NUM_PHASES] = '{50, 30, 50, 50, 50, 50, 55, 30, 30, 30, 30};

    in_item_t              pending_items[$];
    out_item_t             expected_results[$];
    logic [KEY_W-1:0]      offered_keys[$];

    // shadow of the table
    logic [SIZE_W-1:0]     size_reg;
    bit                    used_m    [TABLE_DEPTH];
    logic [KEY_W-1:0]      key_m     [TABLE_DEPTH];
    logic [PAY_OUT_W-1:0]  payload_m [TABLE_DEPTH];
    int unsigned           entries_m;

    int unsigned           items_taken;
    int unsigned           errors;
    int unsigned           quiet_cycles;
    int unsigned           hold_left;
    bit                    hold_req;
    bit                    hold_done;

    double_hash_key_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp_size(int unsigned raw);
        if (raw < SIZE_MIN) return SIZE_MIN;
        if (raw > TABLE_DEPTH) return TABLE_DEPTH;
        return raw;
    endfunction

    // Probe the shadow table and apply one item; return its result.
    function automatic out_item_t apply_item(in_item_t it);
        int unsigned size;
        int unsigned idx;
        int unsigned step;
        int unsigned where;
        int unsigned n;
        bit          stopped;
        out_item_t   res;
        size    = clamp_size(size_reg);
        idx     = it.key % size;
        step    = it.key % (size - 1);
        if (step == 0) step = 1;
        stopped = 1'b0;
        where   = 0;
        for (n = 0; n < size && !stopped; n++) begin
            if (!used_m[idx] || key_m[idx] == it.key) begin
                stopped = 1'b1;
                where   = idx;
            end else begin
                idx = (idx + step) % size;
            end
        end
        res.slot          = '0;
        res.found_payload = '0;
        if (it.action == ACT_INSERT) begin
            if (!stopped) begin
                res.status = ST_FULL;
            end else if (used_m[where]) begin
                res.status        = ST_DUPLICATE;
                res.slot          = SLOT_W'(where);
                res.found_payload = payload_m[where];
            end else if (entries_m + 1 >= size) begin
                // keep one slot empty
                res.status = ST_FULL;
            end else begin
                used_m[where]    = 1'b1;
                key_m[where]     = it.key;
                payload_m[where] = it.payload;
                entries_m        = (entries_m + 1) & 9'h1FF;
                res.status       = ST_INSERTED;
                res.slot         = SLOT_W'(where);
            end
        end else begin
            if (stopped && used_m[where]) begin
                res.status        = ST_FOUND;
                res.slot          = SLOT_W'(where);
                res.found_payload = payload_m[where];
            end else begin
                res.status = ST_NOT_FOUND;
            end
        end
        return res;
    endfunction

    // Idle rates follow the progress through the run.
    function automatic bit sender_pauses();
        if (items_taken < 500) return $urandom_range(99) < 6;
        if (items_taken < 1000) return $urandom_range(99) < 66;
        return 1'b0;
    endfunction

    function automatic bit receiver_pauses();
        if (items_taken < 500) return $urandom_range(99) < 66;
        if (items_taken < 1000) return $urandom_range(99) < 6;
        return 1'b0;
    endfunction

    // Random key, half of them aligned to the size so probe chains form.
    function automatic logic [KEY_W-1:0] fresh_key(int unsigned size);
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        if ($urandom_range(1)) k = KEY_W'((k / size) * size + $urandom_range(3));
        return k;
    endfunction

    function automatic void offer(action_t act, logic [KEY_W-1:0] key,
                                  logic [PAY_OUT_W-1:0] pay);
        in_item_t it;
        it.action  = act;
        it.key     = key;
        it.payload = pay;
        pending_items.push_back(it);
        if (act == ACT_INSERT) offered_keys.push_back(key);
    endfunction

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TABLE_SIZE) size_reg = data[SIZE_W-1:0];
    endtask

    task automatic cfg_read_check(input logic [CFG_ADDR_W-1:0] addr);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== CFG_DATA_W'(size_reg)) begin
            $error("prdata: expected %0d, actual %0d", size_reg, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Check between edges so the driver's pop and valid update are both seen.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: hold the item until accepted, then load the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_item(s_item));
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && !sender_pauses()) begin
                    s_item  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= !receiver_pauses();
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item waiting: status %0d slot %0d",
                       m_item.status, m_item.slot);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_item.status);
                    errors++;
                end
                if (m_item.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, m_item.slot);
                    errors++;
                end
                if (m_item.found_payload !== want.found_payload) begin
                    $error("found_payload: expected %h, actual %h",
                           want.found_payload, m_item.found_payload);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("double_hash_key_table regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned      p;
        int unsigned      n;
        int unsigned      roll;
        int unsigned      eff;
        logic [KEY_W-1:0] k;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        items_taken  = 0;
        errors       = 0;
        quiet_cycles = 0;
        hold_left    = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        size_reg     = SIZE_RESET;
        entries_m    = 0;
        for (n = 0; n < TABLE_DEPTH; n++) used_m[n] = 1'b0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items at the reset size: key and payload extremes,
        // collisions, a zero step, duplicates, hits and misses.
        offer(ACT_INSERT, '0, '0);
        offer(ACT_INSERT, {KEY_W{1'b1}}, {PAY_OUT_W{1'b1}});
        offer(ACT_INSERT, '0, 32'h1234_5678);
        offer(ACT_LOOKUP, {KEY_W{1'b1}}, '0);
        offer(ACT_LOOKUP, KEY_W'(1), {PAY_OUT_W{1'b1}});
        offer(ACT_INSERT, KEY_W'(256), 32'hCAFE_0001);
        offer(ACT_INSERT, KEY_W'(255 * 256), 32'hCAFE_0002);
        offer(ACT_LOOKUP, KEY_W'(255 * 256), '0);
        offer(ACT_INSERT, KEY_W'(512), 32'hCAFE_0003);
        offer(ACT_LOOKUP, KEY_W'(768), '0);
        offer(ACT_INSERT, KEY_W'(32'h5555_5555), 32'hAAAA_AAAA);
        offer(ACT_LOOKUP, KEY_W'(32'h5555_5555), 32'h5555_5555);
        offer(ACT_INSERT, KEY_W'(32'h2AAA_AAAA), 32'h5555_5555);
        offer(ACT_INSERT, KEY_W'(32'h2AAA_AAAA), 32'h0F0F_0F0F);
        offer(ACT_LOOKUP, '0, '0);
        wait_drained();
        cfg_read_check(ADDR_TABLE_SIZE);

        for (p = 0; p < NUM_PHASES; p++) begin
            // unmapped register must be ignored
            cfg_write(ADDR_UNMAPPED, $urandom);
            cfg_write(ADDR_TABLE_SIZE, CFG_DATA_W'(phase_size[p]));
            cfg_read_check(ADDR_TABLE_SIZE);
            eff = clamp_size(phase_size[p]);
            for (n = 0; n < phase_items[p]; n++) begin
                roll = $urandom_range(99);
                if (roll < phase_fresh[p]) begin
                    offer(ACT_INSERT, fresh_key(eff), $urandom);
                end else if (roll < phase_fresh[p] + 15) begin
                    k = offered_keys[$urandom_range(offered_keys.size() - 1)];
                    offer(ACT_INSERT, k, $urandom);
                end else if (roll < phase_fresh[p] + 40) begin
                    k = offered_keys[$urandom_range(offered_keys.size() - 1)];
                    offer(ACT_LOOKUP, k, $urandom);
                end else begin
                    offer(ACT_LOOKUP, fresh_key(eff), $urandom);
                end
            end
            // back up the result side while the long fill phase is offered
            if (phase_size[p] == TABLE_DEPTH) hold_req <= 1'b1;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("double_hash_key_table regression: pass");
        end else begin
            $display("double_hash_key_table regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dhkt_pkg.sv
hdl/dhkt_div.sv
hdl/dhkt_mem.sv
hdl/double_hash_key_table.sv
bench/double_hash_key_table_tb.sv
